// ----- sv/abff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_pkg
// Shared types and constants of the allocation bitmap find-first block.
// ----------------------------------------------------------------------------
package abff_pkg;

  localparam int NUM_BITS_DEF  = 256;
  localparam int WORD_BITS_DEF = 64;

  localparam int MODE_W = 3;
  localparam int IDX_W  = 8;
  localparam int BIU_W  = 9;

  localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY   = 3'd0,
    MODE_SET_BIT = 3'd1,
    MODE_CLR_BIT = 3'd2,
    MODE_SET_ALL = 3'd3,
    MODE_CLR_ALL = 3'd4
  } abff_mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DONE  = 2'd3
  } abff_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  bit_index;
  } abff_in_t;

  typedef struct packed {
    logic             bit_value;
    logic             index_error;
    logic             clear_found;
    logic [IDX_W-1:0] first_clear;
    logic             set_found;
    logic [IDX_W-1:0] first_set;
  } abff_out_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic proc;
    logic wr_zero;
    logic load_out;
  } abff_cmd_t;

  typedef struct packed {
    logic out_busy;
  } abff_sts_t;

endpackage

// ----- sv/abff_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/abff_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_ctrl
// Sequencer: clearing pass after reset, word-by-word read-modify-write scan,
// and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module abff_ctrl
  import abff_pkg::*;
#(
  parameter int NUM_WORDS = 4,
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int CW = $clog2(NUM_WORDS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  abff_sts_t     sts,
  output abff_cmd_t     cmd,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  abff_state_e   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cnt_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt_m1  = cnt_r - CW'(1);
  assign rd_addr = cnt_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    wr_addr   = cnt_m1[AW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_zero = 1'b1;
        wr_addr     = cnt_r[AW-1:0];
        if (cnt_r == CW'(NUM_WORDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = (cnt_r < CW'(NUM_WORDS));
        cmd.proc  = (cnt_r != '0);
        if (cnt_r == CW'(NUM_WORDS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

endmodule

// ----- sv/abff_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abff_dp
// Datapath: bitmap RAM, per-word update and masking, first-clear and
// first-set search, count register and output register.
// ----------------------------------------------------------------------------
module abff_dp
  import abff_pkg::*;
#(
  parameter int NUM_BITS  = NUM_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int OFF_W = $clog2(WORD_BITS),
  localparam int CMP_W = $clog2(NUM_WORDS * WORD_BITS + 512)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  abff_in_t         in_data,
  input  logic             cfg_we,
  input  logic [BIU_W-1:0] cfg_wdata,
  input  abff_cmd_t        cmd,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  output abff_sts_t        sts,
  output logic             out_valid,
  input  logic             out_ready,
  output abff_out_t        out_data
);

  function automatic logic [OFF_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = OFF_W'(i);
      end
    end
    return pos;
  endfunction

  logic [BIU_W-1:0]     biu_r;
  logic [MODE_W-1:0]    mode_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CMP_W-1:0]     base_r;
  logic                 bitval_r;
  logic                 cf_r;
  logic                 sf_r;
  logic [IDX_W-1:0]     fc_r;
  logic [IDX_W-1:0]     fs_r;
  logic                 out_valid_r, out_valid_nxt;
  abff_out_t            out_r;

  logic [CMP_W-1:0]     biu_ext;
  logic [CMP_W-1:0]     limit;
  logic [CMP_W-1:0]     idx_ext;
  logic                 err;
  logic [CMP_W-1:0]     rem;
  logic [CMP_W-1:0]     diff;
  logic                 hit;
  logic [OFF_W-1:0]     off;
  logic [WORD_BITS-1:0] use_mask;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] clr_cand;
  logic [WORD_BITS-1:0] set_cand;
  logic [CMP_W-1:0]     fc_pos;
  logic [CMP_W-1:0]     fs_pos;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;

  // effective count and index check
  assign biu_ext = CMP_W'(biu_r);
  assign limit   = (biu_ext > CMP_W'(NUM_BITS)) ? CMP_W'(NUM_BITS) : biu_ext;
  assign idx_ext = CMP_W'(idx_r);
  assign err     = (idx_ext >= limit);

  // bits of the current word that are in use
  assign rem = limit - base_r;
  always_comb begin
    if (limit <= base_r) begin
      use_mask = '0;
    end else if (rem >= CMP_W'(WORD_BITS)) begin
      use_mask = '1;
    end else begin
      use_mask = ~({WORD_BITS{1'b1}} << rem[OFF_W-1:0]);
    end
  end

  assign diff = idx_ext - base_r;
  assign hit  = (idx_ext >= base_r) && (diff < CMP_W'(WORD_BITS));
  assign off  = diff[OFF_W-1:0];

  always_comb begin
    new_word = rd_word;
    case (mode_r)
      MODE_SET_BIT: begin
        if (hit && !err) begin
          new_word[off] = 1'b1;
        end
      end
      MODE_CLR_BIT: begin
        if (hit && !err) begin
          new_word[off] = 1'b0;
        end
      end
      MODE_SET_ALL: new_word = rd_word | use_mask;
      MODE_CLR_ALL: new_word = rd_word & ~use_mask;
      default:      new_word = rd_word;
    endcase
  end

  assign clr_cand = ~new_word & use_mask;
  assign set_cand = new_word & use_mask;
  assign fc_pos   = base_r + CMP_W'(first_one(clr_cand));
  assign fs_pos   = base_r + CMP_W'(first_one(set_cand));

  assign ram_we    = cmd.proc | cmd.wr_zero;
  assign ram_wdata = cmd.wr_zero ? '0 : new_word;

  abff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= BIU_RESET;
    end else if (cfg_we) begin
      biu_r <= cfg_wdata;
    end
  end

  // item and scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r   <= in_data.mode;
      idx_r    <= in_data.bit_index;
      base_r   <= '0;
      bitval_r <= 1'b0;
      cf_r     <= 1'b0;
      sf_r     <= 1'b0;
      fc_r     <= '0;
      fs_r     <= '0;
    end else if (cmd.proc) begin
      base_r <= base_r + CMP_W'(WORD_BITS);
      if (hit) begin
        bitval_r <= new_word[off];
      end
      if (!cf_r && (clr_cand != '0)) begin
        cf_r <= 1'b1;
        fc_r <= fc_pos[IDX_W-1:0];
      end
      if (!sf_r && (set_cand != '0)) begin
        sf_r <= 1'b1;
        fs_r <= fs_pos[IDX_W-1:0];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.bit_value   <= bitval_r & ~err;
      out_r.index_error <= err;
      out_r.clear_found <= cf_r;
      out_r.first_clear <= fc_r;
      out_r.set_found   <= sf_r;
      out_r.first_set   <= fs_r;
    end
  end

  assign sts.out_busy = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// ----- sv/allocation_bitmap_find_first_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first_core
// Bitmap allocator with set/clear bit, set/clear all, and find-first-clear /
// find-first-set over the first bits_in_use bits.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of NUM_BITS/WORD_BITS words (rounded up). Each
// beat is handled by a read-modify-write sweep over all words, one word per
// cycle, that applies the update and searches for the lowest clear and set
// bit in use. An item passes through the accept cycle, the one-word-per-cycle
// sweep behind the registered RAM read, and a hand-off of the result to the
// output register; the next beat is not taken until the hand-off is done.
// That hand-off waits as long as an earlier result is still held and not
// taken, which stretches the item. After reset a clearing pass zeroes the
// RAM before the first beat is taken. The result sits in an output register,
// so the sweep of the next item can run while it waits.
// ----------------------------------------------------------------------------
module allocation_bitmap_find_first_core
  import abff_pkg::*;
#(
  parameter int NUM_BITS  = NUM_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  abff_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output abff_out_t        out_data,
  input  logic             cfg_we,
  input  logic [BIU_W-1:0] cfg_wdata
);

  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  abff_cmd_t     cmd;
  abff_sts_t     sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  abff_ctrl #(
    .NUM_WORDS (NUM_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  abff_dp #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block accepted a beat while sweeping");

  a_err_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> !out_data.bit_value)
    else $error("bit value reported on an index error");

  a_no_clear_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.clear_found |-> out_data.first_clear == '0)
    else $error("first clear position without a clear bit");

  a_no_set_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.set_found |-> out_data.first_set == '0)
    else $error("first set position without a set bit");
`endif

endmodule
